// File: hw/rtl/obl_pkg.sv
// ---------------------------------------------------------------------------
// obl_pkg
// Shared types and codes for the order book level engine.
// ---------------------------------------------------------------------------
package obl_pkg;

  localparam int unsigned FIELD_W = 48;

  localparam logic [1:0] KIND_SNAP   = 2'd0;
  localparam logic [1:0] KIND_CHANGE = 2'd1;
  localparam logic [1:0] KIND_SETSEQ = 2'd2;
  localparam logic [1:0] KIND_CLEAR  = 2'd3;

  localparam logic [4:0] DEPTH_RESET = 5'd20;

  typedef enum logic [1:0] {
    OP_SNAP,
    OP_CHANGE,
    OP_SETSEQ,
    OP_CLEAR
  } op_t;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_EXEC,
    ST_SRD,
    ST_SCMP,
    ST_DECIDE,
    ST_UP_RD,
    ST_UP_WR,
    ST_DN_RD,
    ST_DN_WR,
    ST_PUT,
    ST_PUB_INIT,
    ST_CMP_RD,
    ST_CMP_CHK,
    ST_EM_INIT,
    ST_EM_EMPTY,
    ST_EM_RD,
    ST_EM_WR
  } state_t;

  typedef struct packed {
    logic [FIELD_W-1:0] price;
    logic [FIELD_W-1:0] volume;
  } level_t;

  typedef struct packed {
    op_t                op;
    logic               side;
    logic [FIELD_W-1:0] price;
    logic [FIELD_W-1:0] volume;
    logic [FIELD_W-1:0] seq;
    logic               last;
    logic               remove;
  } item_t;

  typedef struct packed {
    logic               side;
    logic [4:0]         level_index;
    logic [FIELD_W-1:0] level_price;
    logic [FIELD_W-1:0] level_volume;
    logic               level_valid;
    logic [4:0]         ask_total;
    logic [4:0]         bid_total;
    logic               overflow;
    logic               final_level;
  } res_t;

endpackage

// File: hw/rtl/obl_front.sv
// ---------------------------------------------------------------------------
// obl_front
// Accepts input beats, classifies them and holds them in a two-entry queue.
// ---------------------------------------------------------------------------
module obl_front import obl_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [1:0]         in_kind,
  input  logic               in_side,
  input  logic [FIELD_W-1:0] in_price,
  input  logic [FIELD_W-1:0] in_volume,
  input  logic [FIELD_W-1:0] in_sequence_req,
  input  logic               in_last,
  output logic               q_valid,
  output item_t              q_item,
  input  logic               q_take
);

  item_t      q_mem_r [2];
  logic       wr_ptr_r, rd_ptr_r;
  logic [1:0] cnt_r;
  item_t      cls;
  logic       push;

  always_comb begin
    cls        = '0;
    unique case (in_kind)
      KIND_SNAP:   cls.op = OP_SNAP;
      KIND_CHANGE: cls.op = OP_CHANGE;
      KIND_SETSEQ: cls.op = OP_SETSEQ;
      KIND_CLEAR:  cls.op = OP_CLEAR;
    endcase
    cls.side   = in_side;
    cls.price  = in_price;
    cls.volume = in_volume;
    cls.seq    = in_sequence_req;
    cls.last   = in_last;
    cls.remove = (in_price == '0) || (in_volume == '0);
  end

  assign in_stall = (cnt_r == 2'd2);
  assign push     = in_valid && !in_stall;
  assign q_valid  = (cnt_r != 2'd0);
  assign q_item   = q_mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) q_mem_r[wr_ptr_r] <= cls;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      if (push) wr_ptr_r <= !wr_ptr_r;
      if (q_take) rd_ptr_r <= !rd_ptr_r;
      cnt_r <= cnt_r + 2'(push) - 2'(q_take);
    end
  end

endmodule

// File: hw/rtl/obl_back.sv
// ---------------------------------------------------------------------------
// obl_back
// Carries out queued items on the level memory and publishes the book.
// ---------------------------------------------------------------------------
module obl_back import obl_pkg::*; #(
  parameter int SIDE_CAPACITY = 64,
  parameter int TOP_LEVELS    = 20,
  localparam int CW = $clog2(TOP_LEVELS + 1)
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          q_valid,
  input  item_t         q_item,
  output logic          q_take,
  input  logic [CW-1:0] dsat,
  output logic          out_valid,
  output res_t          out_res,
  input  logic          out_stall
);

  localparam int IW = $clog2(SIDE_CAPACITY);
  localparam int PW = IW + 1;
  localparam int SW = (TOP_LEVELS > 1) ? $clog2(TOP_LEVELS) : 1;

  state_t state_r, state_nxt;
  item_t  cur_r, cur_nxt;
  logic [PW-1:0] pos_r, pos_nxt, j_r, j_nxt;
  logic [PW-1:0] ask_used_r, ask_used_nxt, bid_used_r, bid_used_nxt;
  logic          found_r, found_nxt;
  logic [FIELD_W-1:0] seq_r, seq_nxt;
  logic          ov_r, ov_nxt, ever_r, ever_nxt;
  logic [CW-1:0] shown_na_r, shown_na_nxt, shown_nb_r, shown_nb_nxt;
  logic [CW-1:0] na_r, na_nxt, nb_r, nb_nxt, i_r, i_nxt;
  logic          psd_r, psd_nxt;
  logic          out_valid_r, out_valid_nxt;
  res_t          out_res_r, out_res_nxt;

  level_t mem [2 << IW];
  level_t rd_data_r;
  logic   rd_en, we;
  logic [IW:0] rd_addr, wr_addr;
  level_t wd;

  level_t shown_a_r [TOP_LEVELS];
  level_t shown_b_r [TOP_LEVELS];
  logic   sh_we;

  logic [PW-1:0] n_cur, pos_inc, j_inc, j_dec, dext;
  logic [CW-1:0] na_calc, nb_calc, pub_lim, i_inc;
  logic          hit, ranks, apply, full, slot_free, differ_hdr, em_fin, em_side_end;
  level_t        shown_rd;
  state_t        fin_st;

  assign n_cur     = cur_r.side ? bid_used_r : ask_used_r;
  assign pos_inc   = pos_r + 1'b1;
  assign j_inc     = j_r + 1'b1;
  assign j_dec     = j_r - 1'b1;
  assign hit       = (rd_data_r.price == cur_r.price);
  assign ranks     = cur_r.side ? (cur_r.price > rd_data_r.price)
                                : (cur_r.price < rd_data_r.price);
  assign apply     = (cur_r.op == OP_SNAP) || ((cur_r.op == OP_CHANGE) && (cur_r.seq > seq_r));
  assign full      = (n_cur >= PW'(SIDE_CAPACITY));
  assign slot_free = !out_valid_r || !out_stall;
  assign dext      = PW'(dsat);
  assign na_calc   = CW'((ask_used_r < dext) ? ask_used_r : dext);
  assign nb_calc   = CW'((bid_used_r < dext) ? bid_used_r : dext);
  assign differ_hdr = !ever_r || (na_calc != shown_na_r) || (nb_calc != shown_nb_r);
  assign pub_lim   = psd_r ? nb_r : na_r;
  assign i_inc     = i_r + 1'b1;
  assign shown_rd  = psd_r ? shown_b_r[i_r[SW-1:0]] : shown_a_r[i_r[SW-1:0]];
  assign em_fin    = psd_r ? (i_inc == nb_r) : ((nb_r == '0) && (i_inc == na_r));
  assign em_side_end = !psd_r && (i_inc == na_r);
  assign fin_st    = cur_r.last ? ST_PUB_INIT : ST_IDLE;

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:    if (q_valid) state_nxt = ST_EXEC;
      ST_EXEC: begin
        if (cur_r.op == OP_CLEAR || cur_r.op == OP_SETSEQ) state_nxt = fin_st;
        else state_nxt = apply ? ST_SRD : fin_st;
      end
      ST_SRD:     state_nxt = (pos_r < n_cur) ? ST_SCMP : ST_DECIDE;
      ST_SCMP:    state_nxt = (hit || ranks) ? ST_DECIDE : ST_SRD;
      ST_DECIDE: begin
        if (cur_r.remove) state_nxt = (found_r && pos_inc < n_cur) ? ST_UP_RD : fin_st;
        else if (found_r) state_nxt = fin_st;
        else if (full) begin
          if (pos_r >= PW'(SIDE_CAPACITY)) state_nxt = fin_st;
          else state_nxt = (PW'(SIDE_CAPACITY - 1) > pos_r) ? ST_DN_RD : ST_PUT;
        end else state_nxt = (n_cur > pos_r) ? ST_DN_RD : ST_PUT;
      end
      ST_UP_RD:   state_nxt = ST_UP_WR;
      ST_UP_WR:   state_nxt = (j_inc < n_cur) ? ST_UP_RD : fin_st;
      ST_DN_RD:   state_nxt = ST_DN_WR;
      ST_DN_WR:   state_nxt = (j_dec > pos_r) ? ST_DN_RD : ST_PUT;
      ST_PUT:     state_nxt = fin_st;
      ST_PUB_INIT: state_nxt = differ_hdr ? ST_EM_INIT : ST_CMP_RD;
      ST_CMP_RD: begin
        if (i_r < pub_lim) state_nxt = ST_CMP_CHK;
        else if (psd_r) state_nxt = ST_IDLE;
      end
      ST_CMP_CHK: state_nxt = (rd_data_r != shown_rd) ? ST_EM_INIT : ST_CMP_RD;
      ST_EM_INIT: state_nxt = (na_r == '0 && nb_r == '0) ? ST_EM_EMPTY : ST_EM_RD;
      ST_EM_EMPTY: if (slot_free) state_nxt = ST_IDLE;
      ST_EM_RD:   state_nxt = ST_EM_WR;
      ST_EM_WR:   if (slot_free) state_nxt = em_fin ? ST_IDLE : ST_EM_RD;
      default:    state_nxt = ST_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    q_take = 1'b0;
    cur_nxt = cur_r;
    pos_nxt = pos_r;
    j_nxt = j_r;
    found_nxt = found_r;
    ask_used_nxt = ask_used_r;
    bid_used_nxt = bid_used_r;
    seq_nxt = seq_r;
    ov_nxt = ov_r;
    ever_nxt = ever_r;
    shown_na_nxt = shown_na_r;
    shown_nb_nxt = shown_nb_r;
    na_nxt = na_r;
    nb_nxt = nb_r;
    i_nxt = i_r;
    psd_nxt = psd_r;
    rd_en = 1'b0;
    rd_addr = '0;
    we = 1'b0;
    wr_addr = {cur_r.side, pos_r[IW-1:0]};
    wd = '{price: cur_r.price, volume: cur_r.volume};
    sh_we = 1'b0;
    out_valid_nxt = out_valid_r && out_stall;
    out_res_nxt = out_res_r;
    unique case (state_r)
      ST_IDLE: begin
        q_take = q_valid;
        if (q_valid) cur_nxt = q_item;
      end
      ST_EXEC: begin
        found_nxt = 1'b0;
        pos_nxt = '0;
        if (cur_r.op == OP_CLEAR) begin
          ask_used_nxt = '0;
          bid_used_nxt = '0;
          seq_nxt = '0;
          shown_na_nxt = '0;
          shown_nb_nxt = '0;
          ever_nxt = 1'b0;
          ov_nxt = 1'b0;
        end else if (cur_r.op == OP_SETSEQ) seq_nxt = cur_r.seq;
      end
      ST_SRD: begin
        rd_en = (pos_r < n_cur);
        rd_addr = {cur_r.side, pos_r[IW-1:0]};
      end
      ST_SCMP: begin
        if (hit) found_nxt = 1'b1;
        else if (!ranks) pos_nxt = pos_inc;
      end
      ST_DECIDE: begin
        if (cur_r.remove) begin
          if (found_r) begin
            j_nxt = pos_r;
            if (cur_r.side) bid_used_nxt = n_cur - 1'b1;
            else ask_used_nxt = n_cur - 1'b1;
          end
        end else if (found_r) we = 1'b1;
        else if (full) begin
          ov_nxt = 1'b1;
          j_nxt = PW'(SIDE_CAPACITY - 1);
        end else begin
          j_nxt = n_cur;
          if (cur_r.side) bid_used_nxt = n_cur + 1'b1;
          else ask_used_nxt = n_cur + 1'b1;
        end
      end
      ST_UP_RD: begin
        rd_en = 1'b1;
        rd_addr = {cur_r.side, j_inc[IW-1:0]};
      end
      ST_UP_WR: begin
        we = 1'b1;
        wr_addr = {cur_r.side, j_r[IW-1:0]};
        wd = rd_data_r;
        j_nxt = j_inc;
      end
      ST_DN_RD: begin
        rd_en = 1'b1;
        rd_addr = {cur_r.side, j_dec[IW-1:0]};
      end
      ST_DN_WR: begin
        we = 1'b1;
        wr_addr = {cur_r.side, j_r[IW-1:0]};
        wd = rd_data_r;
        j_nxt = j_dec;
      end
      ST_PUT: we = 1'b1;
      ST_PUB_INIT: begin
        na_nxt = na_calc;
        nb_nxt = nb_calc;
        psd_nxt = 1'b0;
        i_nxt = '0;
      end
      ST_CMP_RD: begin
        if (i_r < pub_lim) begin
          rd_en = 1'b1;
          rd_addr = {psd_r, IW'(i_r)};
        end else if (!psd_r) begin
          psd_nxt = 1'b1;
          i_nxt = '0;
        end
      end
      ST_CMP_CHK: if (rd_data_r == shown_rd) i_nxt = i_inc;
      ST_EM_INIT: begin
        ever_nxt = 1'b1;
        shown_na_nxt = na_r;
        shown_nb_nxt = nb_r;
        psd_nxt = (na_r == '0);
        i_nxt = '0;
      end
      ST_EM_EMPTY: begin
        if (slot_free) begin
          out_valid_nxt = 1'b1;
          out_res_nxt = '0;
          out_res_nxt.overflow = ov_r;
          out_res_nxt.final_level = 1'b1;
          ov_nxt = 1'b0;
        end
      end
      ST_EM_RD: begin
        rd_en = 1'b1;
        rd_addr = {psd_r, IW'(i_r)};
      end
      ST_EM_WR: begin
        if (slot_free) begin
          out_valid_nxt = 1'b1;
          out_res_nxt.side = psd_r;
          out_res_nxt.level_index = 5'(i_r);
          out_res_nxt.level_price = rd_data_r.price;
          out_res_nxt.level_volume = rd_data_r.volume;
          out_res_nxt.level_valid = 1'b1;
          out_res_nxt.ask_total = 5'(na_r);
          out_res_nxt.bid_total = 5'(nb_r);
          out_res_nxt.overflow = ov_r;
          out_res_nxt.final_level = em_fin;
          sh_we = 1'b1;
          if (em_fin) ov_nxt = 1'b0;
          else if (em_side_end) begin
            psd_nxt = 1'b1;
            i_nxt = '0;
          end else i_nxt = i_inc;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (we) mem[wr_addr] <= wd;
    if (rd_en) rd_data_r <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (sh_we) begin
      if (psd_r) shown_b_r[i_r[SW-1:0]] <= rd_data_r;
      else shown_a_r[i_r[SW-1:0]] <= rd_data_r;
    end
  end

  always_ff @(posedge clk) begin
    cur_r <= cur_nxt;
    out_res_r <= out_res_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      pos_r <= '0;
      j_r <= '0;
      found_r <= 1'b0;
      ask_used_r <= '0;
      bid_used_r <= '0;
      seq_r <= '0;
      ov_r <= 1'b0;
      ever_r <= 1'b0;
      shown_na_r <= '0;
      shown_nb_r <= '0;
      na_r <= '0;
      nb_r <= '0;
      i_r <= '0;
      psd_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      pos_r <= pos_nxt;
      j_r <= j_nxt;
      found_r <= found_nxt;
      ask_used_r <= ask_used_nxt;
      bid_used_r <= bid_used_nxt;
      seq_r <= seq_nxt;
      ov_r <= ov_nxt;
      ever_r <= ever_nxt;
      shown_na_r <= shown_na_nxt;
      shown_nb_r <= shown_nb_nxt;
      na_r <= na_nxt;
      nb_r <= nb_nxt;
      i_r <= i_nxt;
      psd_r <= psd_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_res   = out_res_r;

  a_used_bound: assert property (@(posedge clk) disable iff (!rst_n)
    ask_used_r <= PW'(SIDE_CAPACITY) && bid_used_r <= PW'(SIDE_CAPACITY))
    else $error("level count above capacity");

  a_take_idle: assert property (@(posedge clk) disable iff (!rst_n)
    q_take |-> (state_r == ST_IDLE && q_valid))
    else $error("queue popped outside idle");

  a_final_clears_ov: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_nxt && !(out_valid_r && out_stall) && out_res_nxt.final_level) |=> !ov_r)
    else $error("overflow flag kept after publication");

  a_shown_bound: assert property (@(posedge clk) disable iff (!rst_n)
    shown_na_r <= CW'(TOP_LEVELS) && shown_nb_r <= CW'(TOP_LEVELS))
    else $error("published count above top levels");

endmodule

// File: hw/rtl/order_book_level_engine_core.sv
// ---------------------------------------------------------------------------
// order_book_level_engine_core
// Price-level book for one instrument with change-driven publication.
// ---------------------------------------------------------------------------
// Input beats (in_valid/in_stall) carry snapshot levels, sequenced changes,
// set-sequence and clear commands; in_last closes a message and triggers a
// publish check. Result beats (out_valid/out_stall) carry the top levels,
// asks best to worst then bids, when they differ from the last publication.
// cfg_we/cfg_wdata write the published depth; write it only while idle.
// A two-entry queue decouples the input from the engine, so a beat is taken
// while the engine is busy until the queue fills.
// For each item, the price search reads the stored levels one at a time, and
// each level moved on insert or delete costs one read and one write of
// the single-port level memory. A publish check reads and compares the
// published levels one at a time; a publication emits one beat per level
// while the receiver takes them.
// Reset empties the book at once (fill counts only, no memory sweep), sets
// the depth to 20 and clears the sequence and the overflow flag.
// When the receiver stalls, the output register holds its beat and the
// engine waits; the queue then fills and the input stalls.
// ---------------------------------------------------------------------------
module order_book_level_engine_core import obl_pkg::*; #(
  parameter int SIDE_CAPACITY = 64,
  parameter int TOP_LEVELS    = 20
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic [4:0]         cfg_wdata,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [1:0]         in_kind,
  input  logic               in_side,
  input  logic [FIELD_W-1:0] in_price,
  input  logic [FIELD_W-1:0] in_volume,
  input  logic [FIELD_W-1:0] in_sequence_req,
  input  logic               in_last,
  output logic               out_valid,
  input  logic               out_stall,
  output logic               out_side,
  output logic [4:0]         out_level_index,
  output logic [FIELD_W-1:0] out_level_price,
  output logic [FIELD_W-1:0] out_level_volume,
  output logic               out_level_valid,
  output logic [4:0]         out_ask_total,
  output logic [4:0]         out_bid_total,
  output logic               out_overflow,
  output logic               out_final_level
);

  localparam int CW = $clog2(TOP_LEVELS + 1);

  logic [4:0]    depth_r;
  logic [5:0]    dwide;
  logic [CW-1:0] dsat;
  logic          q_valid, q_take;
  item_t         q_item;
  res_t          res;

  // hold the depth register; the user must write it only between messages, the block does not enforce it
  always_ff @(posedge clk) begin
    if (!rst_n) depth_r <= DEPTH_RESET;
    else if (cfg_we) depth_r <= cfg_wdata;
  end

  // clamp the depth to one .. TOP_LEVELS
  always_comb begin
    if (depth_r == '0) dwide = 6'd1;
    else if ({1'b0, depth_r} > 6'(TOP_LEVELS)) dwide = 6'(TOP_LEVELS);
    else dwide = {1'b0, depth_r};
    dsat = CW'(dwide);
  end

  obl_front u_front (
    .clk, .rst_n,
    .in_valid, .in_stall, .in_kind, .in_side, .in_price, .in_volume,
    .in_sequence_req, .in_last,
    .q_valid, .q_item, .q_take
  );

  obl_back #(
    .SIDE_CAPACITY(SIDE_CAPACITY),
    .TOP_LEVELS(TOP_LEVELS)
  ) u_back (
    .clk, .rst_n,
    .q_valid, .q_item, .q_take,
    .dsat,
    .out_valid, .out_res(res), .out_stall
  );

  // split the result beat onto its ports
  assign out_side         = res.side;
  assign out_level_index  = res.level_index;
  assign out_level_price  = res.level_price;
  assign out_level_volume = res.level_volume;
  assign out_level_valid  = res.level_valid;
  assign out_ask_total    = res.ask_total;
  assign out_bid_total    = res.bid_total;
  assign out_overflow     = res.overflow;
  assign out_final_level  = res.final_level;

endmodule
